// ----- hw/rtl/tcd_pkg.sv -----
package tcd_pkg;

  typedef enum logic [2:0] {
    PH_VER  = 3'd0,
    PH_RSV  = 3'd1,
    PH_LENH = 3'd2,
    PH_LENL = 3'd3,
    PH_LI   = 3'd4,
    PH_HDR  = 3'd5,
    PH_DATA = 3'd6,
    PH_SKIP = 3'd7
  } phase_t;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_VERSION = 3'd1;
  localparam logic [2:0] ERR_TPKT_LEN = 3'd2;
  localparam logic [2:0] ERR_LI      = 3'd3;
  localparam logic [2:0] ERR_LI_TYPE = 3'd4;

  localparam logic [3:0] CODE_DT = 4'd15;
  localparam logic [3:0] CODE_CR = 4'd14;
  localparam logic [3:0] CODE_CC = 4'd13;

  localparam logic [7:0]  TPKT_VER_OCTET = 8'd3;
  localparam logic [16:0] TPKT_HDR_LEN   = 17'd4;
  localparam logic [7:0]  DT_MIN_LI      = 8'd2;
  localparam logic [7:0]  CONN_MIN_LI    = 8'd6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  tpdu_code;
    logic [15:0] dst_ref;
    logic [15:0] src_ref;
    logic        eot;
    logic [7:0]  out_byte;
    logic        last;
    logic [2:0]  error_code;
  } result_t;

endpackage

// ----- hw/rtl/tcd_parser.sv -----
module tcd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_in,
  output logic              res_valid,
  output tcd_pkg::result_t  res
);

  tcd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  hlen_r, hlen_nxt;
  logic [7:0]  hidx_r, hidx_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [15:0] dref_r, dref_nxt;
  logic [15:0] sref_r, sref_nxt;
  logic        eot_r, eot_nxt;

  logic [15:0] rem_dec;
  logic [16:0] total;
  logic [7:0]  idx_inc;
  logic        conn_t;
  logic        li_short;
  logic        hdr_done;

  // flags from the state update that steer the result
  logic        ev_err;
  logic [2:0]  ev_code;
  logic        ev_hdr;
  logic        ev_data;

  assign rem_dec = rem_r - 16'd1;
  assign total   = {1'b0, rem_r[15:8], byte_in};
  assign idx_inc = hidx_r + 8'd1;
  // only used on the type octet, whose high nibble is the code
  assign conn_t  = (byte_in[7:4] == tcd_pkg::CODE_CR) || (byte_in[7:4] == tcd_pkg::CODE_CC);
  assign li_short = (idx_inc == 8'd1) &&
                    (((byte_in[7:4] == tcd_pkg::CODE_DT) && (hlen_r < tcd_pkg::DT_MIN_LI)) ||
                     (conn_t && (hlen_r < tcd_pkg::CONN_MIN_LI)));
  assign hdr_done = (idx_inc == hlen_r);

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    hlen_nxt  = hlen_r;
    hidx_nxt  = hidx_r;
    type_nxt  = type_r;
    dref_nxt  = dref_r;
    sref_nxt  = sref_r;
    eot_nxt   = eot_r;
    ev_err    = 1'b0;
    ev_code   = tcd_pkg::ERR_NONE;
    ev_hdr    = 1'b0;
    ev_data   = 1'b0;
    unique case (phase_r)
      tcd_pkg::PH_VER: begin
        if (byte_in != tcd_pkg::TPKT_VER_OCTET) begin
          rem_nxt = '0;
          ev_err  = 1'b1;
          ev_code = tcd_pkg::ERR_VERSION;
        end else begin
          phase_nxt = tcd_pkg::PH_RSV;
        end
      end
      tcd_pkg::PH_RSV: phase_nxt = tcd_pkg::PH_LENH;
      tcd_pkg::PH_LENH: begin
        rem_nxt   = {byte_in, 8'd0};
        phase_nxt = tcd_pkg::PH_LENL;
      end
      tcd_pkg::PH_LENL: begin
        if (total < tcd_pkg::TPKT_HDR_LEN) begin
          rem_nxt   = '0;
          ev_err    = 1'b1;
          ev_code   = tcd_pkg::ERR_TPKT_LEN;
          phase_nxt = tcd_pkg::PH_VER;
        end else begin
          rem_nxt = 16'(total - tcd_pkg::TPKT_HDR_LEN);
          if (16'(total - tcd_pkg::TPKT_HDR_LEN) == 16'd0) begin
            ev_err    = 1'b1;
            ev_code   = tcd_pkg::ERR_LI;
            phase_nxt = tcd_pkg::PH_VER;
          end else begin
            phase_nxt = tcd_pkg::PH_LI;
          end
        end
      end
      tcd_pkg::PH_LI: begin
        rem_nxt  = rem_dec;
        hlen_nxt = byte_in;
        hidx_nxt = '0;
        type_nxt = '0;
        dref_nxt = '0;
        sref_nxt = '0;
        eot_nxt  = 1'b0;
        if ((byte_in == 8'd0) || ({8'd0, byte_in} > rem_dec)) begin
          ev_err    = 1'b1;
          ev_code   = tcd_pkg::ERR_LI;
          phase_nxt = (rem_dec == 16'd0) ? tcd_pkg::PH_VER : tcd_pkg::PH_SKIP;
        end else begin
          phase_nxt = tcd_pkg::PH_HDR;
        end
      end
      tcd_pkg::PH_HDR: begin
        rem_nxt  = rem_dec;
        hidx_nxt = idx_inc;
        if (idx_inc == 8'd1) begin
          type_nxt = byte_in[7:4];
        end else if (type_r == tcd_pkg::CODE_DT) begin
          if (idx_inc == 8'd2) eot_nxt = byte_in[7];
        end else if ((type_r == tcd_pkg::CODE_CR) || (type_r == tcd_pkg::CODE_CC)) begin
          case (idx_inc)
            8'd2:    dref_nxt = {byte_in, 8'd0};
            8'd3:    dref_nxt = {dref_r[15:8], byte_in};
            8'd4:    sref_nxt = {byte_in, 8'd0};
            8'd5:    sref_nxt = {sref_r[15:8], byte_in};
            default: ;
          endcase
        end
        if (li_short) begin
          ev_err    = 1'b1;
          ev_code   = tcd_pkg::ERR_LI_TYPE;
          phase_nxt = (rem_dec == 16'd0) ? tcd_pkg::PH_VER : tcd_pkg::PH_SKIP;
        end else if (hdr_done) begin
          ev_hdr = 1'b1;
          if (rem_dec == 16'd0) begin
            phase_nxt = tcd_pkg::PH_VER;
          end else if (type_nxt == tcd_pkg::CODE_DT) begin
            phase_nxt = tcd_pkg::PH_DATA;
          end else begin
            phase_nxt = tcd_pkg::PH_SKIP;
          end
        end
      end
      tcd_pkg::PH_DATA: begin
        rem_nxt = rem_dec;
        ev_data = 1'b1;
        if (rem_dec == 16'd0) phase_nxt = tcd_pkg::PH_VER;
      end
      tcd_pkg::PH_SKIP: begin
        if (rem_r != 16'd0) rem_nxt = rem_dec;
        if ((rem_r == 16'd0) || (rem_dec == 16'd0)) phase_nxt = tcd_pkg::PH_VER;
      end
    endcase
  end

  always_comb begin
    res       = '0;
    res_valid = ev_err || ev_hdr || ev_data;
    if (ev_err) begin
      res.kind       = tcd_pkg::KIND_ERR;
      res.tpdu_code  = (ev_code == tcd_pkg::ERR_LI_TYPE) ? type_nxt : 4'd0;
      res.last       = 1'b1;
      res.error_code = ev_code;
    end else if (ev_hdr) begin
      res.kind      = tcd_pkg::KIND_HDR;
      res.tpdu_code = type_nxt;
      res.dst_ref   = dref_nxt;
      res.src_ref   = sref_nxt;
      res.eot       = eot_nxt;
      res.last      = !((type_nxt == tcd_pkg::CODE_DT) && (rem_dec != 16'd0));
    end else if (ev_data) begin
      res.kind     = tcd_pkg::KIND_DATA;
      res.out_byte = byte_in;
      res.last     = (rem_dec == 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tcd_pkg::PH_VER;
      rem_r   <= '0;
      hlen_r  <= '0;
      hidx_r  <= '0;
      type_r  <= '0;
      dref_r  <= '0;
      sref_r  <= '0;
      eot_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      hlen_r  <= hlen_nxt;
      hidx_r  <= hidx_nxt;
      type_r  <= type_nxt;
      dref_r  <= dref_nxt;
      sref_r  <= sref_nxt;
      eot_r   <= eot_nxt;
    end
  end

endmodule

// ----- hw/rtl/tpkt_cotp_deframer_core.sv -----
// TPKT / COTP class 0 deframer.
// in_*  : one octet of the TPKT byte stream per item (in_tdata).
// out_* : header, payload byte or error items. out_tuser carries the kind
//         (0 COTP header, 1 DT payload byte, 2 frame error); out_tlast marks
//         the final item of a frame. Octets that produce no item (TPKT header,
//         extra COTP header octets, skipped frame tails) are consumed silently.
// Path: an accepted octet waits in one input register, passes the parser logic,
// and its item is held in one result register that drives out_*.
// Throughput: one octet per cycle while out_* is not stalled; the parser state update is a single
// decrement/compare per octet.
// Stall: while out_tvalid is high and out_tready low, one more octet is held
// in the input register, then in_tready drops until the result is taken.
// Reset (rst_n low, synchronous): both registers empty, parser waits for a
// version octet, frame length and decoded header fields cleared.
module tpkt_cotp_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [3:0] tpdu_code, [19:4] dst_ref, [35:20] src_ref,
                                  // [36] eot, [44:37] out_byte, [47:45] error_code
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  logic             in_v_r;
  logic [7:0]       in_byte_r;
  logic             out_v_r;
  tcd_pkg::result_t out_res_r;
  logic             step;
  logic             res_valid;
  tcd_pkg::result_t res;

  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
  end

  tcd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= res_valid;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) out_res_r <= res;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;
  assign out_tdata  = {out_res_r.error_code, out_res_r.out_byte, out_res_r.eot,
                       out_res_r.src_ref, out_res_r.dst_ref, out_res_r.tpdu_code};

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == tcd_pkg::KIND_ERR) |-> out_tlast)
    else $error("error item without last");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((out_tuser == tcd_pkg::KIND_ERR) == (out_tdata[47:45] != tcd_pkg::ERR_NONE)))
    else $error("error code does not match kind");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_v_r && out_v_r && !out_tready)
    else $error("input stalled with a free slot");

endmodule

// ----- verif/tb_tpkt_cotp_deframer_core.sv -----
module tb_tpkt_cotp_deframer_core;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;   // [3:0] tpdu_code, [19:4] dst_ref, [35:20] src_ref,
                            // [36] eot, [44:37] out_byte, [47:45] error_code
  logic [1:0]  out_tuser;   // [1:0] kind
  logic        out_tlast;

  tpkt_cotp_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  logic [7:0]       octet_q[$];
  logic [7:0]       cotp_body[$];
  tcd_pkg::result_t parsed_q[$];

  int fed = 0;
  int errors = 0;
  int in_gap = 0;
  int out_hold = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  // deframer shadow state
  tcd_pkg::phase_t ph = tcd_pkg::PH_VER;
  logic [15:0] rem = '0;
  logic [7:0]  hlen = '0;
  logic [7:0]  hidx = '0;
  logic [3:0]  tcode = '0;
  logic [15:0] dref = '0;
  logic [15:0] sref = '0;
  logic        eflag = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[tpkt_cotp_deframer_core] ERROR");
    $finish;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit is_conn(input logic [3:0] c);
    return c == tcd_pkg::CODE_CR || c == tcd_pkg::CODE_CC;
  endfunction

  function automatic tcd_pkg::result_t parsed_item(input logic [1:0] kind,
                                                   input logic [3:0] code,
                                                   input logic [15:0] dst,
                                                   input logic [15:0] src,
                                                   input logic eot, input logic [7:0] data,
                                                   input logic last, input logic [2:0] err);
    tcd_pkg::result_t r;
    r.kind       = kind;
    r.tpdu_code  = code;
    r.dst_ref    = dst;
    r.src_ref    = src;
    r.eot        = eot;
    r.out_byte   = data;
    r.last       = last;
    r.error_code = err;
    return r;
  endfunction

  task automatic raise_error(input logic [3:0] code, input logic [2:0] err);
    parsed_q.push_back(parsed_item(tcd_pkg::KIND_ERR, code, 16'h0, 16'h0, 1'b0, 8'h00,
                                   1'b1, err));
    ph = (rem == 0) ? tcd_pkg::PH_VER : tcd_pkg::PH_SKIP;
  endtask

  task automatic deframe_octet(input logic [7:0] b);
    logic [16:0] total;
    logic        more;
    logic        dt;
    logic        bad;
    bad = 1'b0;
    case (ph)
      tcd_pkg::PH_VER: begin
        if (b != tcd_pkg::TPKT_VER_OCTET) begin
          rem = '0;
          raise_error(4'd0, tcd_pkg::ERR_VERSION);
        end else begin
          ph = tcd_pkg::PH_RSV;
        end
      end
      tcd_pkg::PH_RSV: ph = tcd_pkg::PH_LENH;
      tcd_pkg::PH_LENH: begin
        rem = {b, 8'h00};
        ph = tcd_pkg::PH_LENL;
      end
      tcd_pkg::PH_LENL: begin
        total = {1'b0, rem} | {9'd0, b};
        if (total < tcd_pkg::TPKT_HDR_LEN) begin
          rem = '0;
          raise_error(4'd0, tcd_pkg::ERR_TPKT_LEN);
        end else begin
          total = total - tcd_pkg::TPKT_HDR_LEN;
          rem = total[15:0];
          if (rem == 0) raise_error(4'd0, tcd_pkg::ERR_LI);
          else ph = tcd_pkg::PH_LI;
        end
      end
      tcd_pkg::PH_LI: begin
        rem   = rem - 16'd1;
        hlen  = b;
        hidx  = '0;
        tcode = '0;
        dref  = '0;
        sref  = '0;
        eflag = 1'b0;
        if (b == 0 || {8'd0, b} > rem) raise_error(4'd0, tcd_pkg::ERR_LI);
        else ph = tcd_pkg::PH_HDR;
      end
      tcd_pkg::PH_HDR: begin
        rem  = rem - 16'd1;
        hidx = hidx + 8'd1;
        if (hidx == 1) begin
          tcode = b[7:4];
          if ((tcode == tcd_pkg::CODE_DT && hlen < tcd_pkg::DT_MIN_LI) ||
              (is_conn(tcode) && hlen < tcd_pkg::CONN_MIN_LI)) begin
            raise_error(tcode, tcd_pkg::ERR_LI_TYPE);
            bad = 1'b1;
          end
        end else if (tcode == tcd_pkg::CODE_DT) begin
          if (hidx == 2) eflag = b[7];
        end else if (is_conn(tcode)) begin
          case (hidx)
            8'd2: dref = {b, 8'h00};
            8'd3: dref = dref | {8'h00, b};
            8'd4: sref = {b, 8'h00};
            8'd5: sref = sref | {8'h00, b};
            default: ;
          endcase
        end
        if (!bad && hidx == hlen) begin
          dt   = tcode == tcd_pkg::CODE_DT;
          more = rem != 0;
          parsed_q.push_back(parsed_item(tcd_pkg::KIND_HDR, tcode, dref, sref, eflag, 8'h00,
                                         !(dt && more), tcd_pkg::ERR_NONE));
          ph = !more ? tcd_pkg::PH_VER : (dt ? tcd_pkg::PH_DATA : tcd_pkg::PH_SKIP);
        end
      end
      tcd_pkg::PH_DATA: begin
        rem = rem - 16'd1;
        parsed_q.push_back(parsed_item(tcd_pkg::KIND_DATA, 4'd0, 16'h0, 16'h0, 1'b0, b,
                                       rem == 0, tcd_pkg::ERR_NONE));
        if (rem == 0) ph = tcd_pkg::PH_VER;
      end
      tcd_pkg::PH_SKIP: begin
        if (rem != 0) rem = rem - 16'd1;
        if (rem == 0) ph = tcd_pkg::PH_VER;
      end
      default: begin
        ph  = tcd_pkg::PH_VER;
        rem = '0;
      end
    endcase
  endtask

  task automatic push_octet(input logic [7:0] b);
    octet_q.push_back(b);
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) cotp_body.push_back(rnd8());
  endtask

  task automatic start_body(input int li, input logic [3:0] code);
    logic [7:0] r;
    r = rnd8();
    cotp_body.delete();
    cotp_body.push_back(li[7:0]);
    cotp_body.push_back({code, r[3:0]});
  endtask

  // wraps cotp_body in a TPKT header with matching length
  task automatic send_frame();
    logic [15:0] len;
    len = 16'(cotp_body.size() + 4);
    push_octet(tcd_pkg::TPKT_VER_OCTET);
    push_octet(rnd8());
    push_octet(len[15:8]);
    push_octet(len[7:0]);
    foreach (cotp_body[i]) push_octet(cotp_body[i]);
  endtask

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        deframe_octet(in_tdata);
        fed++;
      end
      if ($urandom_range(0, 249) == 0) in_calm = !in_calm;
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (octet_q.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= octet_q.pop_front();
          in_gap = idle_len(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    tcd_pkg::result_t act;
    tcd_pkg::result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        act = parsed_item(out_tuser, out_tdata[3:0], out_tdata[19:4], out_tdata[35:20],
                          out_tdata[36], out_tdata[44:37], out_tlast, out_tdata[47:45]);
        if (parsed_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected item: kind=%0d tdata=%h last=%b", out_tuser, out_tdata,
                     out_tlast);
        end else begin
          want = parsed_q.pop_front();
          if (act.kind !== want.kind || act.tpdu_code !== want.tpdu_code ||
              act.dst_ref !== want.dst_ref || act.src_ref !== want.src_ref ||
              act.eot !== want.eot || act.out_byte !== want.out_byte ||
              act.last !== want.last || act.error_code !== want.error_code) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: exp kind=%0d code=%h dst=%h src=%h eot=%b byte=%h ",
                        "last=%b err=%0d | got kind=%0d code=%h dst=%h src=%h eot=%b ",
                        "byte=%h last=%b err=%0d"},
                       want.kind, want.tpdu_code, want.dst_ref, want.src_ref, want.eot,
                       want.out_byte, want.last, want.error_code,
                       act.kind, act.tpdu_code, act.dst_ref, act.src_ref, act.eot,
                       act.out_byte, act.last, act.error_code);
          end
        end
      end
      if ($urandom_range(0, 249) == 0) out_calm = !out_calm;
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_hold = idle_len(out_calm);
      end
    end
  end

  initial begin
    int total;
    int target;
    int sel;
    int li;
    int k;
    int n;
    logic [3:0] code;
    logic [7:0] b;

    // bad version octets at both ends of the range
    push_octet(8'h00);
    push_octet(8'hFF);
    // TPKT length below header size
    push_octet(tcd_pkg::TPKT_VER_OCTET); push_octet(8'hA5); push_octet(8'h00);
    push_octet(8'h03);
    // empty payload
    cotp_body.delete(); send_frame();
    // one-octet payload
    cotp_body.delete(); cotp_body.push_back(8'h01); send_frame();
    // LI zero, tail skipped
    cotp_body.delete(); cotp_body.push_back(8'h00); add_random(2); send_frame();
    // LI beyond payload
    cotp_body.delete(); cotp_body.push_back(8'h05); cotp_body.push_back(8'hF0); send_frame();
    // DT with LI too short
    start_body(1, tcd_pkg::CODE_DT); send_frame();
    // DT with EOT and two payload octets
    cotp_body = '{8'h02, 8'hF7, 8'h80, 8'hAA, 8'h55}; send_frame();
    // DT, no payload, extra header octet ignored
    cotp_body = '{8'h03, 8'hF0, 8'h7F, 8'hFF}; send_frame();
    // CR with extreme refs and a skipped tail
    cotp_body = '{8'h06, 8'hE0, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h12}; send_frame();
    // CC, header ends the frame
    cotp_body = '{8'h06, 8'hD3, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00}; send_frame();
    // CC and CR with LI too short
    cotp_body = '{8'h05, 8'hD0, 8'h01, 8'h02, 8'h03, 8'h04}; send_frame();
    start_body(3, tcd_pkg::CODE_CR); add_random(2); send_frame();
    // other codes
    cotp_body = '{8'h01, 8'h80}; send_frame();
    cotp_body = '{8'h02, 8'h0F, 8'hFF, 8'h11}; send_frame();

    // frames with a nonzero length high octet
    start_body(2, tcd_pkg::CODE_DT); add_random(1 + 270); send_frame();
    start_body(6, tcd_pkg::CODE_CR); add_random(5 + 280); send_frame();

    target = 1000;
    while (octet_q.size() < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        li = $urandom_range(2, 4);
        start_body(li, tcd_pkg::CODE_DT);
        add_random(li - 1);
        add_random(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12));
        send_frame();
      end else if (sel < 65) begin
        li = $urandom_range(6, 8);
        start_body(li, $urandom_range(0, 1) ? tcd_pkg::CODE_CR : tcd_pkg::CODE_CC);
        add_random(li - 1 + $urandom_range(0, 3));
        send_frame();
      end else if (sel < 75) begin
        code = 4'($urandom_range(0, 12));
        li = $urandom_range(1, 4);
        start_body(li, code);
        add_random(li - 1 + $urandom_range(0, 3));
        send_frame();
      end else if (sel < 90) begin
        case ($urandom_range(0, 5))
          0: begin
            push_octet(tcd_pkg::TPKT_VER_OCTET);
            push_octet(rnd8());
            push_octet(8'h00);
            push_octet(8'($urandom_range(0, 3)));
          end
          1: begin
            cotp_body.delete();
            send_frame();
          end
          2: begin
            cotp_body.delete();
            cotp_body.push_back(rnd8());
            send_frame();
          end
          3: begin
            cotp_body.delete();
            cotp_body.push_back(8'h00);
            add_random($urandom_range(1, 4));
            send_frame();
          end
          4: begin
            k = $urandom_range(1, 4);
            cotp_body.delete();
            cotp_body.push_back(8'(k + $urandom_range(1, 250)));
            add_random(k);
            send_frame();
          end
          default: begin
            if ($urandom_range(0, 1)) begin
              code = tcd_pkg::CODE_DT;
              li = 1;
            end else begin
              code = $urandom_range(0, 1) ? tcd_pkg::CODE_CR : tcd_pkg::CODE_CC;
              li = $urandom_range(1, 5);
            end
            start_body(li, code);
            add_random(li - 1 + $urandom_range(0, 3));
            send_frame();
          end
        endcase
      end else begin
        // line noise, kept off the version value so framing stays aligned
        n = $urandom_range(1, 3);
        repeat (n) begin
          b = rnd8();
          if (b == tcd_pkg::TPKT_VER_OCTET) b = ~b;
          push_octet(b);
        end
      end
    end
    total = octet_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (fed != total || parsed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && parsed_q.size() == 0) begin
      $display("[tpkt_cotp_deframer_core] OK");
    end else begin
      $display("[tpkt_cotp_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
